[design/dmf_pkg.sv]
package dmf_pkg;

    localparam int MAX_CODE_LEN = 1024;
    localparam int SAMPLE_WIDTH = 16;
    localparam int ACC_WIDTH    = 48;

    localparam int CODE_AW  = $clog2(MAX_CODE_LEN);
    localparam int CLEN_W   = CODE_AW + 1;
    localparam int CHIP_W   = 16;
    localparam int PHASE_W  = 15;
    localparam int WPROD_W  = CHIP_W + PHASE_W;
    localparam int W_W      = WPROD_W + 1;
    localparam int SPROD_W  = SAMPLE_WIDTH + W_W;
    localparam int SUM_W    = SPROD_W + 1;
    localparam int FRAC_W   = 28;
    localparam int TERM_W   = SUM_W - FRAC_W;
    localparam int SIC_W    = 8;
    localparam int SPC_W    = 9;
    localparam int BIT_W    = 16;
    localparam int SPC_MAX  = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_CHIP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_RE         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_IM         = 3'd5;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    typedef struct packed {
        logic                     valid;
        logic signed [TERM_W-1:0] re;
        logic signed [TERM_W-1:0] im;
    } t_term;

endpackage

[design/despread_matched_filter.sv]
// Channel   Direction  Handshake              Payload
// in        sink       i_in_valid/o_in_stall  i_cmd, i_chip_slot, i_chip_re/im, i_sample_re/im
// out       source     o_out_valid/i_out_stall o_sum_re/im, o_bit_negative, o_last_of_frame
// cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Loads, starts and samples outside a running frame do not stall the input.
// A correlated sample passes a code table read, four multiplier pipeline
// stages and a wait state that hands the term to the accumulate step, then a
// saturating accumulate; the input stalls until the accumulate step is done.
// Reset returns the counters, accumulators and config registers to their defaults;
// the output result registers are not reset, and the code table holds no defined contents until it is loaded.
// A bit end waits in the accumulate step while the previous result is still
// stalled in the output register.
module despread_matched_filter
    import dmf_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_cmd,
    input  logic [CODE_AW-1:0]             i_chip_slot,
    input  logic signed [CHIP_W-1:0]       i_chip_re,
    input  logic signed [CHIP_W-1:0]       i_chip_im,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_im,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [ACC_WIDTH-1:0]    o_sum_re,
    output logic signed [ACC_WIDTH-1:0]    o_sum_im,
    output logic                           o_bit_negative,
    output logic                           o_last_of_frame,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data
);

    typedef enum logic [1:0] {
        S_READY,
        S_WAIT,
        S_ACC
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SKIP,
        PH_RUN,
        PH_DONE
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [10:0]               r_code_length;
    logic [SPC_W-1:0]          r_samples_per_chip;
    logic [15:0]               r_start_delay;
    logic [BIT_W-1:0]          r_frame_bits;
    logic signed [PHASE_W-1:0] r_phase_re;
    logic signed [PHASE_W-1:0] r_phase_im;

    logic signed [ACC_WIDTH-1:0]    r_acc_re, r_acc_im;
    logic [15:0]                    r_skip_left;
    logic [SIC_W-1:0]               r_sic;
    logic [CODE_AW-1:0]             r_chip_pos;
    logic [BIT_W-1:0]               r_bit_pos;
    logic                           r_rd_pend;
    logic signed [SAMPLE_WIDTH-1:0] r_smp_re, r_smp_im;

    logic                        r_out_valid;
    logic signed [ACC_WIDTH-1:0] r_sum_re, r_sum_im;
    logic                        r_bit_negative, r_last_of_frame;

    logic [CLEN_W-1:0]         clen;
    logic [SPC_W-1:0]          spc;
    logic [BIT_W-1:0]          nb;
    logic [CLEN_W-1:0]         idx_full;
    logic [CODE_AW-1:0]        rd_addr;
    logic                      in_acc;
    logic                      mem_we, mem_re;
    logic [2*CHIP_W-1:0]       mem_rdata;
    t_term                     term;
    logic [15:0]               n_skip_left;
    logic [SPC_W-1:0]          n_sic;
    logic [CLEN_W-1:0]         n_chip_pos;
    logic [BIT_W:0]            n_bit_pos;
    logic                      chip_end, bit_end, frame_end;
    logic                      out_free;
    logic                      out_load;
    logic signed [ACC_WIDTH:0] n_sum_re, n_sum_im;
    logic signed [ACC_WIDTH-1:0] n_acc_re, n_acc_im;

    function automatic logic signed [ACC_WIDTH-1:0] sat_clip(
        input logic signed [ACC_WIDTH:0] v
    );
        logic signed [ACC_WIDTH-1:0] hi;
        hi = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
        if (v[ACC_WIDTH] != v[ACC_WIDTH-1]) begin
            return v[ACC_WIDTH] ? ~hi : hi;
        end
        return v[ACC_WIDTH-1:0];
    endfunction

    always_comb begin
        if (r_code_length == '0) begin
            clen = CLEN_W'(1);
        end else if (32'(r_code_length) > 32'(MAX_CODE_LEN)) begin
            clen = CLEN_W'(MAX_CODE_LEN);
        end else begin
            clen = CLEN_W'(r_code_length);
        end
        if (r_samples_per_chip == '0) begin
            spc = SPC_W'(1);
        end else if (32'(r_samples_per_chip) > 32'(SPC_MAX)) begin
            spc = SPC_W'(SPC_MAX);
        end else begin
            spc = r_samples_per_chip;
        end
        nb = (r_frame_bits == '0) ? BIT_W'(1) : r_frame_bits;

        idx_full = ({1'b0, r_chip_pos} >= clen) ? clen - CLEN_W'(1) : {1'b0, r_chip_pos};
        rd_addr  = idx_full[CODE_AW-1:0];

        in_acc = i_in_valid && !o_in_stall;
        mem_we = in_acc && (i_cmd == CMD_LOAD);
        mem_re = in_acc && (i_cmd == CMD_SAMPLE) && (r_phase == PH_RUN);

        n_skip_left = (r_skip_left != '0) ? r_skip_left - 16'd1 : r_skip_left;

        n_sic      = {1'b0, r_sic} + SPC_W'(1);
        chip_end   = n_sic >= spc;
        n_chip_pos = {1'b0, r_chip_pos} + CLEN_W'(1);
        bit_end    = chip_end && (n_chip_pos >= clen);
        n_bit_pos  = {1'b0, r_bit_pos} + (BIT_W + 1)'(1);
        frame_end  = bit_end && (n_bit_pos >= {1'b0, nb});

        n_sum_re = {r_acc_re[ACC_WIDTH-1], r_acc_re} + (ACC_WIDTH + 1)'(term.re);
        n_sum_im = {r_acc_im[ACC_WIDTH-1], r_acc_im} + (ACC_WIDTH + 1)'(term.im);
        n_acc_re = sat_clip(n_sum_re);
        n_acc_im = sat_clip(n_sum_im);

        out_free = !r_out_valid || !i_out_stall;
        out_load = (r_state == S_ACC) && bit_end && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_READY;
            r_phase            <= PH_IDLE;
            r_code_length      <= 11'd1;
            r_samples_per_chip <= SPC_W'(1);
            r_start_delay      <= 16'd0;
            r_frame_bits       <= BIT_W'(1);
            r_phase_re         <= PHASE_W'(16383);
            r_phase_im         <= '0;
            r_acc_re           <= '0;
            r_acc_im           <= '0;
            r_skip_left        <= '0;
            r_sic              <= '0;
            r_chip_pos         <= '0;
            r_bit_pos          <= '0;
            r_rd_pend          <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            r_rd_pend <= mem_re;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CODE_LENGTH:      r_code_length      <= i_cfg_data[10:0];
                    REG_SAMPLES_PER_CHIP: r_samples_per_chip <= i_cfg_data[SPC_W-1:0];
                    REG_START_DELAY:      r_start_delay      <= i_cfg_data;
                    REG_FRAME_BITS:       r_frame_bits       <= i_cfg_data[BIT_W-1:0];
                    REG_PHASE_RE:         r_phase_re         <= i_cfg_data[PHASE_W-1:0];
                    REG_PHASE_IM:         r_phase_im         <= i_cfg_data[PHASE_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_READY: begin
                    if (in_acc) begin
                        case (i_cmd)
                            CMD_START: begin
                                r_acc_re    <= '0;
                                r_acc_im    <= '0;
                                r_sic       <= '0;
                                r_chip_pos  <= '0;
                                r_bit_pos   <= '0;
                                r_skip_left <= r_start_delay;
                                r_phase     <= (r_start_delay != '0) ? PH_SKIP : PH_RUN;
                            end
                            CMD_SAMPLE: begin
                                if (r_phase == PH_SKIP) begin
                                    r_skip_left <= n_skip_left;
                                    if (n_skip_left == '0) begin
                                        r_phase <= PH_RUN;
                                    end
                                end else if (r_phase == PH_RUN) begin
                                    r_smp_re <= i_sample_re;
                                    r_smp_im <= i_sample_im;
                                    r_state  <= S_WAIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WAIT: begin
                    if (term.valid) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (!bit_end || out_free) begin
                        r_state <= S_READY;
                        r_sic   <= chip_end ? '0 : n_sic[SIC_W-1:0];
                        if (chip_end) begin
                            r_chip_pos <= bit_end ? '0 : n_chip_pos[CODE_AW-1:0];
                        end
                        if (bit_end) begin
                            r_bit_pos       <= n_bit_pos[BIT_W-1:0];
                            r_acc_re        <= '0;
                            r_acc_im        <= '0;
                            r_sum_re        <= n_acc_re;
                            r_sum_im        <= n_acc_im;
                            r_bit_negative  <= n_acc_re[ACC_WIDTH-1];
                            r_last_of_frame <= frame_end;
                            if (frame_end) begin
                                r_phase <= PH_DONE;
                            end
                        end else begin
                            r_acc_re <= n_acc_re;
                            r_acc_im <= n_acc_im;
                        end
                    end
                end
                default: r_state <= S_READY;
            endcase
        end
    end

    dmf_code_mem u_code_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_chip_slot),
        .i_wdata ({i_chip_re, i_chip_im}),
        .i_re    (mem_re),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    dmf_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_rd_pend),
        .i_chip      (mem_rdata),
        .i_phase_re  (r_phase_re),
        .i_phase_im  (r_phase_im),
        .i_sample_re (r_smp_re),
        .i_sample_im (r_smp_im),
        .o_term      (term)
    );

    assign o_in_stall      = (r_state != S_READY);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_sum_re        = r_sum_re;
    assign o_sum_im        = r_sum_im;
    assign o_bit_negative  = r_bit_negative;
    assign o_last_of_frame = r_last_of_frame;

endmodule

[design/dmf_code_mem.sv]
module dmf_code_mem
    import dmf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [CODE_AW-1:0]        i_waddr,
    input  logic [2*CHIP_W-1:0]       i_wdata,
    input  logic                      i_re,
    input  logic [CODE_AW-1:0]        i_raddr,
    output logic [2*CHIP_W-1:0]       o_rdata
);

    logic [2*CHIP_W-1:0] r_mem [MAX_CODE_LEN];
    logic [2*CHIP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/dmf_mac.sv]
module dmf_mac
    import dmf_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [2*CHIP_W-1:0]            i_chip,
    input  logic signed [PHASE_W-1:0]      i_phase_re,
    input  logic signed [PHASE_W-1:0]      i_phase_im,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_im,
    output t_term                          o_term
);

    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [WPROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [W_W-1:0]     r_wr, r_wi;
    logic signed [SPROD_W-1:0] r_q_rr, r_q_ii, r_q_ir, r_q_ri;
    logic signed [TERM_W-1:0]  r_tr, r_ti;

    logic signed [CHIP_W-1:0] chip_re, chip_im;
    logic signed [SUM_W-1:0]  n_sum_re, n_sum_im;

    assign chip_re = i_chip[2*CHIP_W-1:CHIP_W];
    assign chip_im = i_chip[CHIP_W-1:0];

    always_comb begin
        n_sum_re = SUM_W'(r_q_rr) + SUM_W'(r_q_ii) + (SUM_W'(1) <<< (FRAC_W - 1));
        n_sum_im = SUM_W'(r_q_ir) - SUM_W'(r_q_ri) + (SUM_W'(1) <<< (FRAC_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (i_valid) begin
            r_p_rr <= chip_re * i_phase_re;
            r_p_ii <= chip_im * i_phase_im;
            r_p_ri <= chip_re * i_phase_im;
            r_p_ir <= chip_im * i_phase_re;
        end
        if (r_v1) begin
            r_wr <= W_W'(r_p_rr) - W_W'(r_p_ii);
            r_wi <= W_W'(r_p_ri) + W_W'(r_p_ir);
        end
        if (r_v2) begin
            r_q_rr <= i_sample_re * r_wr;
            r_q_ii <= i_sample_im * r_wi;
            r_q_ir <= i_sample_im * r_wr;
            r_q_ri <= i_sample_re * r_wi;
        end
        if (r_v3) begin
            r_tr <= TERM_W'(n_sum_re >>> FRAC_W);
            r_ti <= TERM_W'(n_sum_im >>> FRAC_W);
        end
    end

    assign o_term.valid = r_v4;
    assign o_term.re    = r_tr;
    assign o_term.im    = r_ti;

endmodule
